// ----- rtl/core/kfts_pkg.sv -----
// Shared types, codes and constants for the keyed FIFO with class search.
package kfts_pkg;

    // Default queue depth.
    localparam int DEPTH_DEF = 16;

    // Field widths fixed by the transfer format.
    localparam int KEY_W   = 27;
    localparam int CLASS_W = 2;
    localparam int COUNT_W = 4;
    localparam int OCC_W   = 5;
    localparam int CLASS_N = 4;

    // Saturation limit of the ahead counters.
    localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

    typedef enum logic [2:0] {
        ACT_ENQ    = 3'd0,
        ACT_DEQ    = 3'd1,
        ACT_REMOVE = 3'd2,
        ACT_FIND   = 3'd3,
        ACT_COUNT  = 3'd4
    } kfts_action_t;

    typedef enum logic [1:0] {
        ST_OK   = 2'd0,
        ST_DUP  = 2'd1,
        ST_MISS = 2'd2,
        ST_FULL = 2'd3
    } kfts_status_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SWEEP,
        S_FINISH
    } kfts_state_t;

    // Request item.
    typedef struct packed {
        logic [2:0]         action;
        logic [KEY_W-1:0]   license;
        logic [CLASS_W-1:0] port_type;
    } kfts_in_t;

    // Result item.
    typedef struct packed {
        logic [1:0]         status;
        logic [KEY_W-1:0]   found_license;
        logic [CLASS_W-1:0] found_type;
        logic [COUNT_W-1:0] ahead_count;
        logic               is_empty;
        logic [OCC_W-1:0]   occupancy;
    } kfts_out_t;

    // One queue entry.
    typedef struct packed {
        logic [KEY_W-1:0]   key;
        logic [CLASS_W-1:0] cls;
    } kfts_ent_t;

    // Search results carried along the chain with the sweep token.
    typedef struct packed {
        logic                             key_hit;
        logic                             cls_hit;
        logic [CLASS_N-1:0][COUNT_W-1:0]  cnt;
        logic [COUNT_W-1:0]               ahead;
        logic [KEY_W-1:0]                 fkey;
        logic [CLASS_W-1:0]               fcls;
    } kfts_acc_t;

    // Update command broadcast from the controller to every cell.
    typedef struct packed {
        logic               shift_all;
        logic               shift_rm;
        logic               load;
        logic [KEY_W-1:0]   key;
        logic [CLASS_W-1:0] cls;
    } kfts_cmd_t;

endpackage

// ----- rtl/core/kfts_cell.sv -----
// One queue slot: holds an entry, compares it as the token passes, shifts on removal or dequeue.
module kfts_cell #(
    parameter int DEPTH = kfts_pkg::DEPTH_DEF,
    parameter int IDX   = 0
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic [$clog2(DEPTH+1)-1:0] fill,
    input  kfts_pkg::kfts_in_t         req,
    input  kfts_pkg::kfts_cmd_t        cmd,
    input  logic                       tok_in,
    input  kfts_pkg::kfts_acc_t        acc_in,
    output logic                       tok_out,
    output kfts_pkg::kfts_acc_t        acc_out,
    input  kfts_pkg::kfts_ent_t        nb_ent,
    output kfts_pkg::kfts_ent_t        ent
);
    import kfts_pkg::*;

    localparam int FILL_W = $clog2(DEPTH+1);
    localparam logic [FILL_W-1:0] MY_IDX = FILL_W'(IDX);

    kfts_ent_t ent_reg, ent_next;
    kfts_acc_t acc_reg, acc_next;
    logic      tok_reg;
    logic      rm_reg, rm_next;
    logic      valid, key_match, cls_match;

    // The slot holds a live entry when it lies below the fill level.
    assign valid     = MY_IDX < fill;
    assign key_match = valid && (ent_reg.key == req.license);
    assign cls_match = valid && (ent_reg.cls == req.port_type);

    // Fold this slot into the running search results.
    always_comb
    begin
        acc_next = acc_in;
        if (key_match)
        begin
            acc_next.key_hit = 1'b1;
            acc_next.ahead   = acc_in.cnt[ent_reg.cls];
        end
        if (cls_match && !acc_in.cls_hit)
        begin
            acc_next.cls_hit = 1'b1;
            acc_next.fkey    = ent_reg.key;
            acc_next.fcls    = ent_reg.cls;
        end
        for (int c = 0; c < CLASS_N; c++)
        begin
            if (valid && (ent_reg.cls == CLASS_W'(c)) && (acc_in.cnt[c] != COUNT_MAX))
            begin
                acc_next.cnt[c] = acc_in.cnt[c] + COUNT_W'(1);
            end
        end
    end

    // Remember whether this slot sits at or behind the matched key.
    assign rm_next = tok_in ? (acc_in.key_hit || key_match) : rm_reg;

    // Entry update: close a gap from the right neighbour, or take a new tail entry.
    always_comb
    begin
        ent_next = ent_reg;
        if (cmd.shift_all || (cmd.shift_rm && rm_reg))
        begin
            ent_next = nb_ent;
        end
        else if (cmd.load && (fill == MY_IDX))
        begin
            ent_next.key = cmd.key;
            ent_next.cls = cmd.cls;
        end
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tok_reg <= 1'b0;
            rm_reg  <= 1'b0;
        end
        else
        begin
            tok_reg <= tok_in;
            rm_reg  <= rm_next;
        end
    end

    // Payload state.
    always_ff @(posedge clk)
    begin
        ent_reg <= ent_next;
        if (tok_in)
        begin
            acc_reg <= acc_next;
        end
    end

    assign tok_out = tok_reg;
    assign acc_out = acc_reg;
    assign ent     = ent_reg;

endmodule

// ----- rtl/core/kfts_ctrl.sv -----
// Sequencer: accepts requests, launches sweeps, commits updates and holds the result.
module kfts_ctrl #(
    parameter int DEPTH = kfts_pkg::DEPTH_DEF
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       item_valid,
    output logic                       item_ready,
    input  kfts_pkg::kfts_in_t         item,
    output logic                       result_valid,
    input  logic                       result_ready,
    output kfts_pkg::kfts_out_t        result,
    output logic                       launch,
    output kfts_pkg::kfts_in_t         req,
    output kfts_pkg::kfts_cmd_t        cmd,
    output logic [$clog2(DEPTH+1)-1:0] fill,
    input  logic                       sweep_done,
    input  kfts_pkg::kfts_acc_t        sweep_acc,
    input  kfts_pkg::kfts_ent_t        head
);
    import kfts_pkg::*;

    localparam int FILL_W = $clog2(DEPTH+1);
    localparam logic [FILL_W-1:0] FULL_LEVEL = FILL_W'(DEPTH);

    kfts_state_t         state_reg, state_next;
    kfts_in_t            req_reg, req_next;
    logic                launch_reg, launch_next;
    logic [FILL_W-1:0]   fill_reg, fill_next;
    logic                res_valid_reg, res_valid_next;
    kfts_out_t           res_reg, res_next;
    logic                accept, needs_sweep, out_free, commit;
    logic [FILL_W+4:0]   occ_wide;

    assign item_ready = (state_reg == S_IDLE);
    assign accept     = item_valid && item_ready;
    assign out_free   = !res_valid_reg || result_ready;
    assign commit     = (state_reg == S_FINISH) && out_free;

    // Actions that look up a key or class go through the cell chain.
    always_comb
    begin
        case (item.action) inside
            ACT_ENQ, ACT_REMOVE, ACT_FIND, ACT_COUNT: needs_sweep = 1'b1;
            default:                                  needs_sweep = 1'b0;
        endcase
    end

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    state_next = needs_sweep ? S_SWEEP : S_FINISH;
                end
            end
            S_SWEEP:
            begin
                if (sweep_done)
                begin
                    state_next = S_FINISH;
                end
            end
            S_FINISH:
            begin
                if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    // Outputs: cell commands, fill update and the result word.
    always_comb
    begin
        req_next    = accept ? item : req_reg;
        launch_next = accept && needs_sweep;
        fill_next   = fill_reg;

        cmd           = '0;
        cmd.key       = req_reg.license;
        cmd.cls       = req_reg.port_type;

        res_next = '0;
        res_next.status = ST_OK;

        unique case (req_reg.action)
            ACT_ENQ:
            begin
                if (sweep_acc.key_hit)
                begin
                    res_next.status = ST_DUP;
                end
                else if (fill_reg == FULL_LEVEL)
                begin
                    res_next.status = ST_FULL;
                end
                else
                begin
                    cmd.load  = commit;
                    fill_next = commit ? fill_reg + FILL_W'(1) : fill_reg;
                end
            end
            ACT_DEQ:
            begin
                if (fill_reg == '0)
                begin
                    res_next.status = ST_MISS;
                end
                else
                begin
                    res_next.found_license = head.key;
                    res_next.found_type    = head.cls;
                    cmd.shift_all          = commit;
                    fill_next = commit ? fill_reg - FILL_W'(1) : fill_reg;
                end
            end
            ACT_REMOVE:
            begin
                if (!sweep_acc.key_hit)
                begin
                    res_next.status = ST_MISS;
                end
                else
                begin
                    cmd.shift_rm = commit;
                    fill_next    = commit ? fill_reg - FILL_W'(1) : fill_reg;
                end
            end
            ACT_FIND:
            begin
                if (sweep_acc.cls_hit)
                begin
                    res_next.found_license = sweep_acc.fkey;
                    res_next.found_type    = sweep_acc.fcls;
                end
                else
                begin
                    res_next.status = ST_MISS;
                end
            end
            ACT_COUNT:
            begin
                if (sweep_acc.key_hit)
                begin
                    res_next.ahead_count = sweep_acc.ahead;
                end
                else
                begin
                    res_next.status = ST_MISS;
                end
            end
            default:
            begin
                res_next.status = ST_OK;
            end
        endcase

        // Occupancy reports the low bits of the fill level after the step.
        occ_wide           = {5'd0, fill_next};
        res_next.occupancy = occ_wide[OCC_W-1:0];
        res_next.is_empty  = (fill_next == '0);

        if (commit)
        begin
            res_valid_next = 1'b1;
        end
        else
        begin
            res_valid_next = res_valid_reg && !result_ready;
        end
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            launch_reg    <= 1'b0;
            fill_reg      <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            launch_reg    <= launch_next;
            fill_reg      <= fill_next;
            res_valid_reg <= res_valid_next;
        end
    end

    // Payload state.
    always_ff @(posedge clk)
    begin
        req_reg <= req_next;
        if (commit)
        begin
            res_reg <= res_next;
        end
    end

    assign launch       = launch_reg;
    assign req          = req_reg;
    assign fill         = fill_reg;
    assign result_valid = res_valid_reg;
    assign result       = res_reg;

endmodule

// ----- rtl/core/keyed_fifo_with_type_search.sv -----
// Top level of the keyed FIFO with class search: controller and chain of slot cells.
//
// Requests arrive on the item channel (item_valid / item_ready, payload item) and each
// produces exactly one transfer on the result channel (result_valid / result_ready).
// Actions: enqueue (duplicate keys ignored, full queue drops), dequeue, remove by key,
// find first of a class, and count same-class entries ahead of a key.
// Lookups run as a token that walks the row of DEPTH cells, one cell per cycle,
// collecting key match, first class match and per-class counts; the length of that
// row sets the timing. Enqueue, remove, find and count commit once the token leaves
// the tail cell; a new request is taken only when the controller is idle again.
// Dequeue and undefined actions need no lookup and go straight to the result step.
// A removal closes the gap in a single shift, every cell at or behind the match
// copying its right neighbour; dequeue shifts the whole row the same way.
// The result register parts the two channels: the next request is accepted while a
// result waits, and its update is held back until that result has been taken.
// Reset empties the queue at once; entry contents are not cleared and are never
// read before being written.
module keyed_fifo_with_type_search #(
    parameter int DEPTH = kfts_pkg::DEPTH_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                item_valid,
    output logic                item_ready,
    input  kfts_pkg::kfts_in_t  item,
    output logic                result_valid,
    input  logic                result_ready,
    output kfts_pkg::kfts_out_t result
);
    import kfts_pkg::*;

    localparam int FILL_W = $clog2(DEPTH+1);

    logic              launch;
    kfts_in_t          req;
    kfts_cmd_t         cmd;
    logic [FILL_W-1:0] fill;

    logic      tok_chain [DEPTH+1];
    kfts_acc_t acc_chain [DEPTH+1];
    kfts_ent_t ent_chain [DEPTH+1];

    // The token enters at the head with cleared search results; nothing lies past the tail.
    assign tok_chain[0]     = launch;
    assign acc_chain[0]     = '0;
    assign ent_chain[DEPTH] = '0;

    kfts_ctrl #(
        .DEPTH (DEPTH)
    ) u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_ready   (item_ready),
        .item         (item),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result),
        .launch       (launch),
        .req          (req),
        .cmd          (cmd),
        .fill         (fill),
        .sweep_done   (tok_chain[DEPTH]),
        .sweep_acc    (acc_chain[DEPTH]),
        .head         (ent_chain[0])
    );

    // Row of slot cells, head at index zero.
    for (genvar i = 0; i < DEPTH; i++)
    begin : g_cell
        kfts_cell #(
            .DEPTH (DEPTH),
            .IDX   (i)
        ) u_cell (
            .clk     (clk),
            .rst_n   (rst_n),
            .fill    (fill),
            .req     (req),
            .cmd     (cmd),
            .tok_in  (tok_chain[i]),
            .acc_in  (acc_chain[i]),
            .tok_out (tok_chain[i+1]),
            .acc_out (acc_chain[i+1]),
            .nb_ent  (ent_chain[i+1]),
            .ent     (ent_chain[i])
        );
    end

endmodule

// ----- rtl/core/kfts_check.sv -----
// Port-level checker for the keyed FIFO with class search, bound to the top level.
module kfts_check (
    input logic                clk,
    input logic                rst_n,
    input logic                item_valid,
    input logic                item_ready,
    input kfts_pkg::kfts_in_t  item,
    input logic                result_valid,
    input logic                result_ready,
    input kfts_pkg::kfts_out_t result
);
    import kfts_pkg::*;

    // A stalled request transfer keeps its payload.
    a_item_hold: assert property (@(posedge clk) disable iff (!rst_n)
        item_valid && !item_ready |=> item_valid && $stable(item))
        else $error("request changed while stalled");

    // A stalled result transfer keeps its payload.
    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_ready |=> result_valid && $stable(result))
        else $error("result changed while stalled");

    // Requests are handled one at a time.
    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        item_valid && item_ready |=> !item_ready)
        else $error("request accepted while another is in progress");

    // An empty queue reports no occupancy.
    a_empty_occ: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result.is_empty |-> result.occupancy == '0)
        else $error("empty flag with non-zero occupancy");

    // Duplicate and full answers carry no found entry and no count.
    a_reject_clean: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && (result.status == ST_DUP || result.status == ST_FULL)
        |-> result.found_license == '0 && result.found_type == '0
            && result.ahead_count == '0)
        else $error("rejected enqueue returned entry data");

endmodule

bind keyed_fifo_with_type_search kfts_check u_kfts_check (.*);
